>>> rtl/lbhq_pkg.sv
// package for the log-binned histogram quantile block
// types, constants and controller/datapath command and status structs
// no dependencies
package lbhq_pkg;

	localparam int BinCount  = 2048;
	localparam int BinW      = $clog2(BinCount);
	localparam int IdxW      = BinW + 1;
	localparam int TotalW    = 32 + BinW;
	localparam int TargetW   = TotalW + 17;

	localparam logic [1:0] OpInit     = 2'd0;
	localparam logic [1:0] OpInsert   = 2'd1;
	localparam logic [1:0] OpQuantile = 2'd2;

	localparam logic [1:0] RegLowest  = 2'd0;
	localparam logic [1:0] RegHighest = 2'd1;
	localparam logic [1:0] RegRatio   = 2'd2;

	localparam logic [31:0] LowestReset  = 32'd65536;
	localparam logic [31:0] HighestReset = 32'd65536000;
	localparam logic [30:0] RatioReset   = 31'd1077370000;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_INIT,
		ST_INIT_MUL,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_INS_RD,
		ST_INS_WR,
		ST_SUM,
		ST_SCAN,
		ST_FIN_RD,
		ST_FIN,
		ST_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;        // capture request fields, clear indexes
		logic init_step;   // compute/write one bound and clear one counter
		logic init_mul;    // register bound product
		logic srch_rd;     // issue bound reads at mid, mid+1
		logic srch_cmp;    // compare and narrow the search
		logic ins_rd;      // read counter of found bin
		logic ins_wr;      // write incremented counter, form result
		logic sum_step;    // accumulate one counter
		logic scan_step;   // scan one counter
		logic fin_rd;      // read bound for quantile result
		logic fin;         // form quantile result
		logic zero;        // form all-zero result
		logic clr_step;    // clear one counter after reset
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       clr_last;
		logic       init_last;
		logic       srch_done;
		logic       sum_last;
		logic       scan_hit;
		logic       scan_last;
	} stat_t;

endpackage

>>> rtl/lbhq_if.sv
// valid/ready channel carrying a packed payload
// depends on nothing
interface lbhq_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/lbhq_ctrl.sv
// controller state machine for the histogram block
// depends on lbhq_pkg
module lbhq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output lbhq_pkg::cmd_t  cmd,
	input  lbhq_pkg::stat_t stat
);
	import lbhq_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:      state_d = stat.clr_last ? ST_IDLE : ST_CLR;
			ST_IDLE: if (in_valid) begin
				unique case (stat.op)
					OpInit:     state_d = ST_INIT;
					OpInsert:   state_d = ST_SRCH_RD;
					OpQuantile: state_d = ST_SUM;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_INIT:     state_d = stat.init_last ? ST_DONE : ST_INIT_MUL;
			ST_INIT_MUL: state_d = ST_INIT;
			ST_SRCH_RD:  state_d = ST_SRCH_CMP;
			ST_SRCH_CMP: state_d = stat.srch_done ? ST_INS_RD : ST_SRCH_RD;
			ST_INS_RD:   state_d = ST_INS_WR;
			ST_INS_WR:   state_d = ST_DONE;
			ST_SUM:      state_d = stat.sum_last ? ST_SCAN : ST_SUM;
			ST_SCAN:     state_d = (stat.scan_hit || stat.scan_last) ? ST_FIN_RD : ST_SCAN;
			ST_FIN_RD:   state_d = ST_FIN;
			ST_FIN:      state_d = ST_DONE;
			ST_DONE:     if (out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_DONE);
		unique case (state_q)
			ST_CLR:      cmd.clr_step = 1'b1;
			ST_IDLE: begin
				cmd.load = in_valid;
				cmd.zero = in_valid;
			end
			ST_INIT:     cmd.init_step = 1'b1;
			ST_INIT_MUL: cmd.init_mul = 1'b1;
			ST_SRCH_RD:  cmd.srch_rd = 1'b1;
			ST_SRCH_CMP: cmd.srch_cmp = 1'b1;
			ST_INS_RD:   cmd.ins_rd = 1'b1;
			ST_INS_WR:   cmd.ins_wr = 1'b1;
			ST_SUM:      cmd.sum_step = 1'b1;
			ST_SCAN:     cmd.scan_step = 1'b1;
			ST_FIN_RD:   cmd.fin_rd = 1'b1;
			ST_FIN:      cmd.fin = 1'b1;
			default:     ;
		endcase
	end

`ifndef ASSERT_OFF
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_ready) |=> state_q == ST_DONE)
		else $error("result dropped");
	a_accept_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != ST_IDLE) else $error("request lost");
`endif
endmodule

>>> rtl/lbhq_dp.sv
// datapath: bound memory, counter memory, search, sum and scan
// depends on lbhq_pkg
module lbhq_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lbhq_pkg::cmd_t                cmd,
	output lbhq_pkg::stat_t               stat,
	input  logic [1:0]                    in_operation,
	input  logic [31:0]                   in_sample,
	input  logic [16:0]                   in_quantile,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic [lbhq_pkg::BinW:0]       res_bin_index,
	output logic [31:0]                   res_lower_bound,
	output logic [31:0]                   res_count,
	output logic [47:0]                   res_remainder,
	output logic                          res_past_end
);
	import lbhq_pkg::*;

	logic [31:0] lowest_q, highest_q;
	logic [30:0] ratio_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q  <= LowestReset;
			highest_q <= HighestReset;
			ratio_q   <= RatioReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegLowest:  lowest_q  <= cfg_data;
				RegHighest: highest_q <= cfg_data;
				RegRatio:   ratio_q   <= cfg_data[30:0];
				default:    ;
			endcase
		end
	end

	// captured request
	logic [1:0]  op_q;
	logic [31:0] sample_q;
	logic [16:0] quant_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_operation;
			sample_q <= in_sample;
			quant_q  <= in_quantile;
		end
	end

	// bound memory, two read ports (banked as two copies), one write port
	logic [31:0] bnd_a_mem [BinCount+1];
	logic [31:0] bnd_b_mem [BinCount+1];
	logic [BinW:0] bwa, bra, brb;
	logic        bwe;
	logic [31:0] bwd, brd_a_q, brd_b_q;
	always_ff @(posedge clk) begin
		if (bwe) begin
			bnd_a_mem[bwa] <= bwd;
			bnd_b_mem[bwa] <= bwd;
		end
		brd_a_q <= bnd_a_mem[bra];
		brd_b_q <= bnd_b_mem[brb];
	end

	// counter memory, zeroed by a clearing pass after reset and by initialize
	logic [31:0] cnt_mem [BinCount];
	logic [BinW-1:0] cwa, cra;
	logic        cwe;
	logic [31:0] cwd, crd_raw_q;
	always_ff @(posedge clk) begin
		if (cwe) cnt_mem[cwa] <= cwd;
		crd_raw_q <= cnt_mem[cra];
	end
	logic [31:0] crd;
	assign crd = crd_raw_q;

	// working registers
	logic [BinW:0]   idx_q;      // clear / init / sum / scan index
	logic [31:0]     prev_q;     // previous bound during init
	logic [31:0]     bound0_q;   // first bound written by initialize
	logic [62:0]     prod_q;
	logic [BinW:0]   lo_q, hi_q, mid_q;
	logic [BinW-1:0] bin_q;
	logic            found_q;
	logic            rd_pend_q;
	logic [TotalW-1:0] total_q, before_q;
	logic [TargetW-1:0] target_q;
	logic            hit_q;
	logic            ins_lb_q;

	logic [BinW:0] mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	logic [TotalW+15:0] cum_sh;
	assign cum_sh = {before_q + TotalW'(crd), 16'd0};

	// search finish: early hit, below range, or range exhausted
	logic srch_hit;
	logic [BinW-1:0] srch_bin;
	always_comb begin
		srch_hit = 1'b0;
		srch_bin = BinW'(BinCount - 1);
		if (sample_q < bound0_q) begin
			srch_hit = 1'b1; srch_bin = '0;
		end else if (sample_q >= brd_b_q) begin
			srch_hit = 1'b0;
		end else if (sample_q >= brd_a_q) begin
			srch_hit = 1'b1; srch_bin = mid_q[BinW-1:0];
		end
	end

	logic [BinW:0] lo_n, hi_n;
	always_comb begin
		lo_n = lo_q; hi_n = hi_q;
		if (sample_q >= brd_b_q) lo_n = mid_q + 1'b1;
		else if (sample_q < brd_a_q) hi_n = mid_q;
	end

	// memory address and write control
	always_comb begin
		bwe = 1'b0; bwa = idx_q; bwd = prev_q;
		cwe = 1'b0; cwa = idx_q[BinW-1:0]; cwd = '0;
		bra = mid_q; brb = mid_q + 1'b1;
		cra = idx_q[BinW-1:0];
		if (cmd.clr_step) cwe = 1'b1;
		if (cmd.init_step) begin
			bwe = 1'b1;
			cwe = (idx_q < (BinW+1)'(BinCount));
			if (idx_q == '0) bwd = lowest_q;
			else if (idx_q == (BinW+1)'(BinCount)) bwd = highest_q;
			else bwd = (prod_q[62:30] > 33'hFFFFFFFF) ? 32'hFFFFFFFF : prod_q[61:30];
		end
		if (cmd.srch_rd) begin
			bra = mid; brb = mid + 1'b1;
		end
		if (cmd.ins_rd || cmd.ins_wr) begin
			cra = bin_q;
			bra = {1'b0, bin_q};
		end
		if (cmd.ins_wr) begin
			cwe = 1'b1; cwa = bin_q;
			cwd = (crd == 32'hFFFFFFFF) ? crd : crd + 32'd1;
		end
		if (cmd.fin_rd) bra = hit_q ? idx_q : (BinW+1)'(BinCount);
		if (cmd.sum_step || cmd.scan_step) cra = idx_q[BinW-1:0] + (rd_pend_q ? 1'b1 : 1'b0);
	end

	// sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0; lo_q <= '0; hi_q <= '0; mid_q <= '0; bin_q <= '0;
			found_q <= 1'b0; rd_pend_q <= 1'b0; hit_q <= 1'b0;
			total_q <= '0; before_q <= '0; target_q <= '0;
			prev_q <= '0; bound0_q <= '0;
		end else begin
			// clearing pass after reset
			if (cmd.clr_step) idx_q <= idx_q + 1'b1;
			if (cmd.load) begin
				idx_q <= '0; lo_q <= '0; hi_q <= (BinW+1)'(BinCount);
				found_q <= 1'b0; rd_pend_q <= 1'b0; hit_q <= 1'b0;
				total_q <= '0; before_q <= '0;
			end
			// init: write one entry, alternating with the bound multiply
			if (cmd.init_step) begin
				prev_q <= bwd;
				idx_q <= idx_q + 1'b1;
				if (idx_q == '0) bound0_q <= lowest_q;
			end
			// search: compare bounds read at mid, mid+1
			if (cmd.srch_rd) mid_q <= mid;
			if (cmd.srch_cmp) begin
				if (sample_q < bound0_q && !found_q) begin
					found_q <= 1'b1; bin_q <= '0;
				end else if (sample_q >= brd_b_q) lo_q <= mid_q + 1'b1;
				else if (sample_q < brd_a_q) hi_q <= mid_q;
				else begin
					found_q <= 1'b1; bin_q <= mid_q[BinW-1:0];
				end
			end
			if (cmd.srch_cmp && stat.srch_done && !found_q && !srch_hit)
				bin_q <= srch_bin;
			// sum: pipelined read, one counter per cycle
			if (cmd.sum_step) begin
				if (stat.sum_last) begin
					target_q <= TargetW'(total_q + TotalW'(crd)) * TargetW'(quant_q);
					idx_q <= '0; rd_pend_q <= 1'b0;
				end else begin
					rd_pend_q <= 1'b1;
					if (rd_pend_q) begin
						total_q <= total_q + TotalW'(crd);
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			// scan: first bin whose cumulative count reaches target
			if (cmd.scan_step) begin
				rd_pend_q <= 1'b1;
				if (rd_pend_q) begin
					if (TargetW'(cum_sh) >= target_q) hit_q <= 1'b1;
					else begin
						before_q <= before_q + TotalW'(crd);
						idx_q <= idx_q + 1'b1;
					end
				end
			end
		end
	end

	// status
	logic cum_ge;
	assign cum_ge = TargetW'(cum_sh) >= target_q;
	always_comb begin
		stat.op        = cmd.load ? in_operation : op_q;
		stat.clr_last  = (idx_q == (BinW+1)'(BinCount - 1));
		stat.init_last = (idx_q == (BinW+1)'(BinCount));
		stat.srch_done = srch_hit || (lo_n >= hi_n);
		stat.sum_last  = rd_pend_q && (idx_q == (BinW+1)'(BinCount - 1));
		stat.scan_hit  = rd_pend_q && cum_ge;
		stat.scan_last = rd_pend_q && !cum_ge && (idx_q == (BinW+1)'(BinCount - 1));
	end

	// bound product register
	always_ff @(posedge clk) begin
		if (cmd.init_mul) prod_q <= prev_q * ratio_q;
	end

	// insert: bound read issued with counter read, taken with the counter write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ins_lb_q <= 1'b0;
		else ins_lb_q <= cmd.ins_rd;
	end

	// result register
	logic [BinW:0] scan_idx_q;
	logic [31:0]   scan_cnt_q;
	logic [47:0]   scan_rem_q;
	always_ff @(posedge clk) begin
		if (cmd.scan_step && stat.scan_hit) begin
			scan_cnt_q <= crd;
			scan_rem_q <= 48'(target_q - TargetW'({before_q, 16'd0}));
		end
		if (cmd.scan_step) scan_idx_q <= idx_q;
		if (cmd.zero) begin
			res_bin_index <= '0; res_lower_bound <= '0; res_count <= '0;
			res_remainder <= '0; res_past_end <= 1'b0;
		end
		if (cmd.ins_wr) begin
			res_bin_index <= {1'b0, bin_q};
			res_count     <= cwd;
		end
		if (cmd.fin) begin
			res_lower_bound <= brd_a_q;
			if (hit_q) begin
				res_bin_index <= scan_idx_q;
				res_count     <= scan_cnt_q;
				res_remainder <= scan_rem_q;
			end else begin
				res_bin_index <= (BinW+1)'(BinCount);
				res_past_end  <= 1'b1;
			end
		end
		if (ins_lb_q) res_lower_bound <= brd_a_q;
	end

`ifndef ASSERT_OFF
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> (cwd >= crd)) else $error("counter wrapped");
	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_cmp |-> lo_q <= hi_q) else $error("search range inverted");
	a_past_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.fin) |-> (res_past_end == (res_bin_index == (BinW+1)'(BinCount))))
		else $error("past end flag mismatch");
`endif
endmodule

>>> rtl/log_binned_histogram_quantile.sv
// top level of the log-binned histogram quantile block
// depends on lbhq_pkg, lbhq_if, lbhq_ctrl, lbhq_dp
//
// channel  dir  payload
// req      in   operation, sample, quantile_fraction
// rsp      out  bin_index, bin_lower_bound, bin_count, remainder_in_bin, past_end
// cfg      in   index (2 bit), data (32 bit)
//
// insert: one read/compare state pair per search step (at most 12 steps, one when
// below range), then a counter read and write; quantile: a sum pass over the
// counters, then a scan; initialize: one bound multiply per entry.
// after reset a clearing pass zeroes the counters; requests wait for it; bounds
// undefined until initialize.
// one request in flight; the result waits for rsp.ready, then the next is taken.
module log_binned_histogram_quantile (
	input  logic clk,
	input  logic arst_n,
	lbhq_if.sink   req,
	lbhq_if.source rsp,
	lbhq_if.sink   cfg
);
	import lbhq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// config always accepted
	assign cfg.ready = 1'b1;

	lbhq_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd, .stat
	);

	logic [BinW:0] bin_index;
	logic [31:0]   lower_bound, count;
	logic [47:0]   remainder;
	logic          past_end;

	lbhq_dp u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_operation(req.data[50:49]),
		.in_sample(req.data[48:17]),
		.in_quantile(req.data[16:0]),
		.cfg_we(cfg.valid),
		.cfg_index(cfg.data[33:32]),
		.cfg_data(cfg.data[31:0]),
		.res_bin_index(bin_index),
		.res_lower_bound(lower_bound),
		.res_count(count),
		.res_remainder(remainder),
		.res_past_end(past_end)
	);

	assign rsp.data = {bin_index, lower_bound, count, remainder, past_end};
endmodule
